>>> rtl/mavg_pkg.sv
// shared types and constants for the moving average filter
package mavg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd3;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_DIV    = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

endpackage

>>> rtl/moving_average_filter.sv
// boxcar moving average filter over signed q8.8 samples
//
// Each accepted sample goes into a 16-bit sample memory that holds the last
// window_length samples, and a running sum is updated with a single
// read-modify-write of that memory: the oldest sample is read in the accept
// cycle, and the sum and the memory are updated in the following one. Until
// window_length samples have arrived since reset or the last write of the
// window register, no result is produced and each sample goes from the update
// step straight back to idle. Once the window is full, every sample yields one
// average, the running sum divided by the window length and truncated toward
// zero. The division is a restoring divider that produces one quotient bit per
// cycle, and no new sample is taken until the result has been loaded into an
// output register. The core then goes on with the next sample while that
// result waits to be taken. Any write of the window register, even with an
// unchanged value, empties the window. A window length of zero acts as one,
// and values above MAX_WINDOW are saturated to MAX_WINDOW. The sample memory
// needs no clearing pass: only entries written since the window was emptied
// ever enter the running sum.
module moving_average_filter
    import mavg_pkg::*;
#(
    parameter int MAX_WINDOW = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    // window length register write
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,     // [4:0] window_length
    // sample input
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,    // [15:0] sample
    // average output
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata     // [15:0] average
);

    // memory index and running sum widths follow from the largest window
    localparam int PTR_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W     = SAMPLE_W + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 0);
    localparam int CNT_W     = $clog2(SUM_W);
    localparam int LEN_W     = CFG_W;
    localparam int CMP_W     = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
    // the register can only express windows up to 31 samples
    localparam int MAX_CLAMP = (MAX_WINDOW > 31) ? 31 : MAX_WINDOW;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CLAMP);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SUM_W - 1);

    // sample memory, one write and one registered read port
    logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // control state
    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     window_reg;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [LEN_W-1:0]     fill_reg, fill_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [PTR_W-1:0]     slot_reg;
    logic [SAMPLE_W-1:0]  sample_reg;

    // divider state
    logic [SUM_W-1:0]     quo_reg;
    logic [LEN_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 neg_reg;

    // output register
    logic                 out_valid_reg;
    logic [SAMPLE_W-1:0]  out_data_reg;

    logic [LEN_W-1:0]     len;
    logic [PTR_W-1:0]     slot;
    logic [CMP_W-1:0]     slot_inc;
    logic                 in_accept;
    logic                 window_full;
    logic [SUM_W-1:0]     sum_abs;
    logic [LEN_W:0]       trial;
    logic                 trial_ge;
    logic [SUM_W-1:0]     quo_signed;
    logic                 out_load;

    // effective window length
    always_comb
    begin
        if (window_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (window_reg > LEN_MAX)
        begin
            len = LEN_MAX;
        end
        else
        begin
            len = window_reg;
        end
    end

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // slot to replace, wrapped into the current window
    assign slot = (CMP_W'(ptr_reg) >= CMP_W'(len)) ? '0 : ptr_reg;

    // running sum, fill and pointer update of the read-modify-write step
    assign window_full = (fill_reg >= len);
    always_comb
    begin
        sum_next = sum_reg
                 - (window_full ? SUM_W'(signed'(rd_data_reg)) : '0)
                 + SUM_W'(signed'(sample_reg));
        fill_next = window_full ? len : fill_reg + LEN_W'(1);
        slot_inc  = CMP_W'(slot_reg) + CMP_W'(1);
        ptr_next  = (slot_inc >= CMP_W'(len)) ? '0 : slot_inc[PTR_W-1:0];
    end

    assign sum_abs = sum_next[SUM_W-1] ? (~sum_next + SUM_W'(1)) : sum_next;

    // one restoring step per cycle
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, len});

    assign quo_signed = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = (fill_next >= len) ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_END)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sample memory: oldest entry read at accept, new sample written back next cycle
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_data_reg <= ring_mem[slot];
        end
        if (state_reg == S_UPDATE)
        begin
            ring_mem[slot_reg] <= sample_reg;
        end
    end

    // payload and divider datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= s_axis_tdata;
            slot_reg   <= slot;
        end
        if (state_reg == S_UPDATE)
        begin
            quo_reg <= sum_abs;
            neg_reg <= sum_next[SUM_W-1];
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], trial_ge};
            rem_reg <= trial_ge ? LEN_W'(trial - {1'b0, len}) : trial[LEN_W-1:0];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (out_load)
        begin
            out_data_reg <= quo_signed[SAMPLE_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WINDOW_RESET;
            sum_reg       <= '0;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                // any write empties the window
                window_reg <= cfg_wr_data;
                sum_reg    <= '0;
                fill_reg   <= '0;
                ptr_reg    <= '0;
            end
            else if (state_reg == S_UPDATE)
            begin
                sum_reg  <= sum_next;
                fill_reg <= fill_next;
                ptr_reg  <= ptr_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/mavg_checker.sv
// port-level checks for the moving average filter, bound to the top level
module mavg_checker
    import mavg_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [SAMPLE_W-1:0] m_axis_tdata
);

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled average changed or dropped");

    // one sample in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a sample transaction");

    // a result never shows up in the cycle right after a sample transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("average appeared too early");

    // no result pending as reset is released
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid out of reset");

endmodule

bind moving_average_filter mavg_checker u_mavg_checker (.*);
